>>> rtl/utf8_stream_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared assertion wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_STREAM_DECODER_UNIT_MACROS_SVH

// Checks that a condition holds at every clock edge.
`define UTF8D_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Widths, constants and the state and result types shared by the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 22;
  localparam int PEND_W = 2;

  localparam logic [BYTE_W-1:0] LEAD_MASK  = 8'h7F;
  localparam logic [1:0]        CONT_PFX   = 2'b10;
  localparam int                CONT_BITS  = 6;

  typedef struct packed {
    logic [PEND_W-1:0] pending;
    logic [CP_W-1:0]   partial;
    logic              err;
  } dec_state_t;

  typedef struct packed {
    logic            valid;
    logic [CP_W-1:0] code_point;
    logic            bad;
  } dec_result_t;

endpackage

>>> rtl/utf8d_step.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder step
// Combinational decode of one byte against the open sequence state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8d_step import utf8d_pkg::*; (
  input  logic [BYTE_W-1:0] data_byte,
  input  dec_state_t        st,
  output dec_state_t        st_nxt,
  output dec_result_t       res
);

  logic [CP_W-1:0]   cont_pv;
  logic              cont_err;
  logic [PEND_W-1:0] lead_cnt;
  logic [BYTE_W-1:0] lead_bits;

  assign cont_pv  = {st.partial[CP_W-CONT_BITS-1:0], data_byte[CONT_BITS-1:0]};
  assign cont_err = st.err | (data_byte[BYTE_W-1:BYTE_W-2] != CONT_PFX);
  assign lead_cnt = !data_byte[6] ? 2'd0 :
                    !data_byte[5] ? 2'd1 :
                    !data_byte[4] ? 2'd2 : 2'd3;
  assign lead_bits = data_byte & (LEAD_MASK >> lead_cnt);

  always_comb begin
    st_nxt = st;
    res    = '0;
    priority if (st.pending != '0) begin
      if (st.pending == 2'd1) begin
        res.valid      = 1'b1;
        res.code_point = cont_pv;
        res.bad        = cont_err;
        st_nxt         = '0;
      end else begin
        st_nxt.pending = st.pending - 2'd1;
        st_nxt.partial = cont_pv;
        st_nxt.err     = cont_err;
      end
    end else if (!data_byte[BYTE_W-1] || (lead_cnt == '0)) begin
      res.valid      = 1'b1;
      res.code_point = CP_W'(data_byte & LEAD_MASK);
      res.bad        = 1'b0;
    end else begin
      st_nxt.pending = lead_cnt;
      st_nxt.partial = CP_W'(lead_bits);
      st_nxt.err     = 1'b0;
    end
  end

endmodule

>>> rtl/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder unit
// Rebuilds code points from a byte stream, one byte per request.
// ----------------------------------------------------------------------------
// The unit accepts one byte per clock cycle while in_stall is low. The byte
// that completes a code point passes the input register, then the decode step
// that feeds the result register. The sustained rate of one byte per cycle is
// set by the single decode step, which updates the sequence state as each byte
// leaves the input register; a stalled result only holds the input side once
// both the input register and the result register are full.
`timescale 1ns / 1ps

module utf8_stream_decoder_unit import utf8d_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CP_W-1:0]   out_code_point,
  output logic              out_bad_sequence
);

`include "utf8_stream_decoder_unit_macros.svh"

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  dec_state_t        st_r;
  dec_state_t        st_nxt;
  dec_result_t       res;
  logic              out_valid_r;
  logic [CP_W-1:0]   out_cp_r;
  logic              out_bad_r;
  logic              out_free;
  logic              s1_fire;
  logic              in_accept;

  utf8d_step u_step (
    .data_byte (s1_byte_r),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && (out_free || !res.valid);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        st_r <= st_nxt;
      end
      if (s1_fire && res.valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_byte;
    end
    if (s1_fire && res.valid) begin
      out_cp_r  <= res.code_point;
      out_bad_r <= res.bad;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_code_point   = out_cp_r;
  assign out_bad_sequence = out_bad_r;

  `UTF8D_ASSERT_ALWAYS(a_idle_no_err, (st_r.pending != '0) || !st_r.err, "error flag set with no open sequence")
  `UTF8D_ASSERT_ALWAYS(a_idle_no_partial, (st_r.pending != '0) || (st_r.partial == '0), "partial value left with no open sequence")
  `UTF8D_ASSERT_ALWAYS(a_stall_held, !in_stall || s1_valid_r, "input stalled with an empty input register")
  `UTF8D_ASSERT_NEXT(a_result_loaded, s1_fire && res.valid, out_valid_r, "decoded result not presented")

endmodule
